// ----- rtl/core/gss_pkg.sv -----
// gss_pkg: shared codes, widths and controller/datapath handshake structs
// for the grid step sequencer. No dependencies.
package gss_pkg;

  // input command codes (s_tuser)
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_WRITE_CELL = 3'd1;
  localparam logic [2:0] CMD_WRITE_NOTE = 3'd2;
  localparam logic [2:0] CMD_START      = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;

  // output event kinds (m_tuser)
  localparam logic [1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [1:0] EV_TRIGGER  = 2'd2;
  localparam logic [1:0] EV_STATUS   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_OUTPUT_MODE  = 3'd0;
  localparam logic [2:0] REG_ACTIVE_SEQ   = 3'd1;
  localparam logic [2:0] REG_STEPS        = 3'd2;
  localparam logic [2:0] REG_NOTE_LENGTH  = 3'd3;
  localparam logic [2:0] REG_LOOP         = 3'd4;
  localparam logic [2:0] REG_AUTO_CYCLE   = 3'd5;
  localparam logic [2:0] REG_LINEAR_CYCLE = 3'd6;
  localparam logic [2:0] REG_MIDI_CHANNEL = 3'd7;

  // port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 6;

  // controller to datapath
  typedef struct packed {
    logic       clr;
    logic       accept;
    logic       tk_ev;
    logic       set_rd;
    logic       set_wr;
    logic       fl_scan;
    logic       row_inc;
    logic       emit;
    logic [1:0] kind;
  } gss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic clr_done;
    logic out_free;
    logic go_tick;
    logic go_flush;
    logic ev_any;
    logic ev_von;
    logic v_nz;
    logic midi;
    logic last_row;
    logic fl_done;
    logic fl_any;
  } gss_stat_t;

endpackage

// ----- rtl/core/gss_ram.sv -----
// gss_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
module gss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gss_ctrl.sv -----
// gss_ctrl: sequencing state machine of the grid step sequencer.
// Depends on gss_pkg; drives gss_dp through command and status structs.
module gss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  gss_pkg::gss_stat_t st,
  output gss_pkg::gss_cmd_t  cmd,
  output logic              in_ready
);
  import gss_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_TK_RD   = 12'b000000000100,
    S_TK_EV   = 12'b000000001000,
    S_TK_OFF  = 12'b000000010000,
    S_TK_ON   = 12'b000000100000,
    S_TK_SRD  = 12'b000001000000,
    S_TK_SWR  = 12'b000010000000,
    S_FL_SCAN = 12'b000100000000,
    S_FL_EMIT = 12'b001000000000,
    S_STATUS  = 12'b010000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (st.in_valid) begin
          cmd.accept = 1'b1;
          if (st.go_tick)       state_next = S_TK_RD;
          else if (st.go_flush) state_next = S_FL_SCAN;
          else                  state_next = S_STATUS;
        end
      end
      S_TK_RD: begin
        state_next = S_TK_EV;
      end
      S_TK_EV: begin
        cmd.tk_ev = 1'b1;
        if (st.ev_any)      state_next = S_TK_OFF;
        else if (st.ev_von) state_next = S_TK_ON;
        else if (st.last_row) state_next = S_STATUS;
        else begin
          cmd.row_inc = 1'b1;
          state_next  = S_TK_RD;
        end
      end
      S_TK_OFF: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EV_NOTE_OFF;
          if (st.v_nz)          state_next = S_TK_ON;
          else if (st.last_row) state_next = S_STATUS;
          else begin
            cmd.row_inc = 1'b1;
            state_next  = S_TK_RD;
          end
        end
      end
      S_TK_ON: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = st.midi ? EV_NOTE_ON : EV_TRIGGER;
          if (st.midi)          state_next = S_TK_SRD;
          else if (st.last_row) state_next = S_STATUS;
          else begin
            cmd.row_inc = 1'b1;
            state_next  = S_TK_RD;
          end
        end
      end
      S_TK_SRD: begin
        cmd.set_rd = 1'b1;
        state_next = S_TK_SWR;
      end
      S_TK_SWR: begin
        cmd.set_wr = 1'b1;
        if (st.last_row) state_next = S_STATUS;
        else begin
          cmd.row_inc = 1'b1;
          state_next  = S_TK_RD;
        end
      end
      S_FL_SCAN: begin
        cmd.fl_scan = 1'b1;
        if (st.fl_done) state_next = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (!st.fl_any || st.out_free) begin
          cmd.emit = st.fl_any;
          cmd.kind = EV_NOTE_OFF;
          if (st.last_row) state_next = S_STATUS;
          else begin
            cmd.row_inc = 1'b1;
            state_next  = S_FL_SCAN;
          end
        end
      end
      S_STATUS: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EV_STATUS;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/core/gss_dp.sv -----
// gss_dp: datapath of the grid step sequencer: config registers, play
// position, pattern and pending note-off rams, row notes, output register.
// Depends on gss_pkg and gss_ram.
module gss_dp #(
  parameter int SEQUENCES = 8,
  parameter int ROWS      = 12,
  parameter int COLUMNS   = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gss_pkg::gss_cmd_t                   cmd,
  output gss_pkg::gss_stat_t                  st,
  input  logic                                s_tvalid,
  input  logic [gss_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gss_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  input  logic [2:0]                          cfg_index,
  input  logic [gss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gss_pkg::*;

  localparam int COL_W      = $clog2(COLUMNS);
  localparam int STEP_W     = COL_W + 1;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SEQ_W      = $clog2(SEQUENCES + 1);
  localparam int SIDX_W     = (SEQUENCES > 1) ? $clog2(SEQUENCES) : 1;
  localparam int PAT_DEPTH  = SEQUENCES * ROWS * COLUMNS;
  localparam int PAT_AW     = $clog2(PAT_DEPTH);
  localparam int PEND_DEPTH = ROWS * COLUMNS;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);

  // config registers
  logic       mode;
  logic [3:0] act_reg;
  logic [5:0] steps_reg;
  logic [4:0] len_reg;
  logic       loop_en;
  logic       auto_cyc;
  logic       lin_cyc;
  logic [3:0] chan_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      act_reg   <= 4'd1;
      steps_reg <= 6'd16;
      len_reg   <= 5'd1;
      loop_en   <= 1'b1;
      auto_cyc  <= 1'b0;
      lin_cyc   <= 1'b0;
      chan_reg  <= 4'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OUTPUT_MODE:  mode      <= cfg_data[0];
        REG_ACTIVE_SEQ:   act_reg   <= cfg_data[3:0];
        REG_STEPS:        steps_reg <= cfg_data[5:0];
        REG_NOTE_LENGTH:  len_reg   <= cfg_data[4:0];
        REG_LOOP:         loop_en   <= cfg_data[0];
        REG_AUTO_CYCLE:   auto_cyc  <= cfg_data[0];
        REG_LINEAR_CYCLE: lin_cyc   <= cfg_data[0];
        REG_MIDI_CHANNEL: chan_reg  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // saturated lengths and clamped note length
  logic [STEP_W-1:0] steps_s;
  logic [SEQ_W-1:0]  act_s;
  logic [STEP_W-1:0] lenc;
  always_comb begin
    if (steps_reg == 6'd0)                steps_s = STEP_W'(1);
    else if (7'(steps_reg) > 7'(COLUMNS)) steps_s = STEP_W'(COLUMNS);
    else                                  steps_s = STEP_W'(steps_reg);
    if (act_reg == 4'd0)                  act_s = SEQ_W'(1);
    else if (5'(act_reg) > 5'(SEQUENCES)) act_s = SEQ_W'(SEQUENCES);
    else                                  act_s = SEQ_W'(act_reg);
    if (7'(len_reg) >= 7'(steps_s))       lenc = steps_s - STEP_W'(1);
    else                                  lenc = STEP_W'(len_reg);
  end

  // input fields
  logic [2:0] in_cmd;
  logic [2:0] in_seq;
  logic [3:0] in_row;
  logic [4:0] in_col;
  logic [6:0] in_val;
  assign in_cmd = s_tuser;
  assign in_seq = s_tdata[2:0];
  assign in_row = s_tdata[6:3];
  assign in_col = s_tdata[11:7];
  assign in_val = s_tdata[18:12];

  // play position
  logic [COL_W-1:0] col, wcol;
  logic [SEQ_W-1:0] seq, wseq;
  logic             run;
  logic             runnable;
  logic [STEP_W-1:0] col1;
  logic [SEQ_W-1:0]  seq1;
  logic              run1;

  assign runnable = run && ({1'b0, col} < steps_s) && (seq < act_s);

  // position after one played step
  always_comb begin
    col1 = {1'b0, col} + STEP_W'(1);
    seq1 = seq;
    run1 = 1'b1;
    if (col1 == steps_s && loop_en) col1 = '0;
    if (auto_cyc && col1 == steps_s) begin
      seq1 = seq + SEQ_W'(1);
      col1 = '0;
      if (seq1 == act_s && !lin_cyc) seq1 = '0;
    end
    if (col1 >= steps_s) begin
      col1 = '0;
      run1 = 1'b0;
    end
    if (seq1 >= act_s) run1 = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      seq <= '0;
      run <= 1'b0;
    end else if (cmd.accept) begin
      case (in_cmd)
        CMD_TICK: begin
          if (runnable) begin
            col <= COL_W'(col1);
            seq <= seq1;
            run <= run1;
          end else begin
            run <= 1'b0;
          end
        end
        CMD_START: begin
          col <= '0;
          seq <= '0;
          run <= 1'b1;
        end
        CMD_STOP: run <= 1'b0;
        default: ;
      endcase
    end
  end

  // working copy of the position being played
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wcol <= col;
      wseq <= seq;
    end
  end

  // row notes
  logic [6:0] row_notes [ROWS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) row_notes[i] <= '0;
    end else if (cmd.accept && in_cmd == CMD_WRITE_NOTE && 5'(in_row) < 5'(ROWS)) begin
      row_notes[ROW_W'(in_row)] <= in_val;
    end
  end

  // row and flush counters
  logic [ROW_W-1:0] rcnt;
  logic [COL_W:0]   fc;
  logic             fv;
  logic             fany;
  logic [6:0]       vl;
  logic [COL_W-1:0] fcp;
  logic             fc_live;

  assign fcp     = COL_W'(fc - (COL_W + 1)'(1));
  assign fc_live = (fc != (COL_W + 1)'(COLUMNS));

  // active sequence mask
  logic [SEQUENCES-1:0] amask;
  always_comb begin
    for (int s = 0; s < SEQUENCES; s++) amask[s] = (SEQ_W'(s) < act_s);
  end

  // note-off column
  logic [STEP_W:0]  off_sum;
  logic [COL_W-1:0] off;
  always_comb begin
    off_sum = (STEP_W + 1)'(wcol) + (STEP_W + 1)'(lenc);
    if (off_sum >= (STEP_W + 1)'(steps_s)) off_sum = off_sum - (STEP_W + 1)'(steps_s);
    off = COL_W'(off_sum);
  end

  // clear sweep counter
  logic [PAT_AW-1:0] ccnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
    end else if (cmd.clr) begin
      ccnt <= ccnt + PAT_AW'(1);
    end
  end

  // rams
  logic                 pat_we;
  logic [PAT_AW-1:0]    pat_waddr, pat_raddr;
  logic [6:0]           pat_wdata, pat_rdata;
  logic                 pend_we;
  logic [PEND_AW-1:0]   pend_waddr, pend_raddr;
  logic [SEQUENCES-1:0] pend_wdata, pend_rdata, seq_bit;

  logic in_cell_ok;
  assign in_cell_ok = (5'(in_seq) < 5'(SEQUENCES)) && (5'(in_row) < 5'(ROWS))
                   && (7'(in_col) < 7'(COLUMNS));

  always_comb begin
    seq_bit = '0;
    seq_bit[SIDX_W'(wseq)] = 1'b1;
  end

  // pattern ram ports
  always_comb begin
    pat_we    = cmd.clr || (cmd.accept && in_cmd == CMD_WRITE_CELL && in_cell_ok);
    pat_waddr = cmd.clr ? ccnt
              : PAT_AW'((32'(in_seq) * ROWS + 32'(in_row)) * COLUMNS + 32'(in_col));
    pat_wdata = cmd.clr ? 7'd0 : in_val;
    pat_raddr = PAT_AW'((32'(wseq) * ROWS + 32'(rcnt)) * COLUMNS + 32'(wcol));
  end

  // pending note-off ram ports
  always_comb begin
    pend_we    = 1'b0;
    pend_waddr = PEND_AW'(32'(rcnt) * COLUMNS + 32'(wcol));
    pend_wdata = '0;
    if (cmd.clr) begin
      pend_we    = (32'(ccnt) < PEND_DEPTH);
      pend_waddr = PEND_AW'(ccnt);
    end else if (cmd.tk_ev) begin
      pend_we    = !mode;
      pend_wdata = pend_rdata & ~amask;
    end else if (cmd.set_wr) begin
      pend_we    = 1'b1;
      pend_waddr = PEND_AW'(32'(rcnt) * COLUMNS + 32'(off));
      pend_wdata = pend_rdata | seq_bit;
    end else if (cmd.fl_scan) begin
      pend_we    = fv;
      pend_waddr = PEND_AW'(32'(rcnt) * COLUMNS + 32'(fcp));
    end
    if (cmd.set_rd)       pend_raddr = PEND_AW'(32'(rcnt) * COLUMNS + 32'(off));
    else if (cmd.fl_scan) pend_raddr = PEND_AW'(32'(rcnt) * COLUMNS + 32'(fc[COL_W-1:0]));
    else                  pend_raddr = PEND_AW'(32'(rcnt) * COLUMNS + 32'(wcol));
  end

  gss_ram #(.WIDTH(7), .DEPTH(PAT_DEPTH)) u_pat (
    .clk  (clk),
    .we   (pat_we),
    .waddr(pat_waddr),
    .wdata(pat_wdata),
    .raddr(pat_raddr),
    .rdata(pat_rdata)
  );

  gss_ram #(.WIDTH(SEQUENCES), .DEPTH(PEND_DEPTH)) u_pend (
    .clk  (clk),
    .we   (pend_we),
    .waddr(pend_waddr),
    .wdata(pend_wdata),
    .raddr(pend_raddr),
    .rdata(pend_rdata)
  );

  // row walk and flush scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      fc   <= '0;
      fv   <= 1'b0;
      fany <= 1'b0;
    end else if (cmd.accept || cmd.row_inc) begin
      rcnt <= cmd.accept ? '0 : rcnt + ROW_W'(1);
      fc   <= '0;
      fv   <= 1'b0;
      fany <= 1'b0;
    end else if (cmd.fl_scan) begin
      fv <= fc_live;
      if (fc_live) fc <= fc + (COL_W + 1)'(1);
      if (fv) fany <= fany | (|pend_rdata);
    end
  end

  // cell velocity of the row being played
  always_ff @(posedge clk) begin
    if (cmd.tk_ev) vl <= pat_rdata;
  end

  // output register
  logic [1:0] o_kind;
  logic [3:0] o_row, o_chan, o_seq;
  logic [6:0] o_note, o_vel;
  logic [4:0] o_col;
  logic       o_run;
  logic       is_stat, is_on;

  assign is_stat = (cmd.kind == EV_STATUS);
  assign is_on   = (cmd.kind == EV_NOTE_ON) || (cmd.kind == EV_TRIGGER);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kind <= cmd.kind;
      o_row  <= is_stat ? 4'd0 : 4'(rcnt);
      o_note <= is_stat ? 7'd0 : row_notes[rcnt];
      o_vel  <= is_on ? vl : 7'd0;
      o_chan <= (cmd.kind == EV_NOTE_ON || cmd.kind == EV_NOTE_OFF) ? chan_reg : 4'd0;
      o_col  <= 5'(col);
      o_seq  <= 4'(seq);
      o_run  <= run;
    end
  end

  assign m_tdata = {o_run, o_seq, o_col, o_chan, o_vel, o_note, o_row};
  assign m_tuser = o_kind;
  assign m_tlast = (o_kind == EV_STATUS);

  // status to the controller
  always_comb begin
    st.in_valid = s_tvalid;
    st.clr_done = (ccnt == PAT_AW'(PAT_DEPTH - 1));
    st.out_free = !m_tvalid || m_tready;
    st.go_tick  = (in_cmd == CMD_TICK) && runnable;
    st.go_flush = ((in_cmd == CMD_TICK) && !runnable) || (in_cmd == CMD_START)
               || (in_cmd == CMD_STOP);
    st.ev_any   = !mode && (|(pend_rdata & amask));
    st.ev_von   = (pat_rdata != 7'd0);
    st.v_nz     = (vl != 7'd0);
    st.midi     = !mode;
    st.last_row = (rcnt == ROW_W'(ROWS - 1));
    st.fl_done  = !fc_live;
    st.fl_any   = fany;
  end

endmodule

// ----- rtl/core/grid_step_sequencer_top.sv -----
// grid_step_sequencer_top: top level of the grid step sequencer.
// Depends on gss_pkg, gss_ctrl, gss_dp (which holds the gss_ram instances).
//
// Usage:
//  - s_* channel takes one command beat: tick, write cell, write row note,
//    start, stop. Only one command is in flight; s_tready is high when idle.
//  - m_* channel returns the events of that command (note on, note off,
//    sample trigger) followed by exactly one status beat with m_tlast high.
//  - cfg_* channel writes a register by index; always ready. Write it
//    only while the block is idle; the block does not enforce this.
//  - A tick walks the rows one after another, and its event beats leave
//    during that walk. A flush (start, stop, tick while stopped) scans the
//    pending note-off ram row by row, one column a cycle.
//  - Reset: a clearing pass zeroes both rams, one entry a cycle over
//    SEQUENCES*ROWS*COLUMNS addresses, with s_tready low.
//  - A stalled m_tready holds the current beat and pauses the row walk.
module grid_step_sequencer_top #(
  parameter int SEQUENCES = 8,
  parameter int ROWS      = 12,
  parameter int COLUMNS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gss_pkg::IN_DATA_W-1:0]  s_tdata,   // seq_index, row_index, column_index, value
  input  logic [2:0]                     s_tuser,   // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gss_pkg::OUT_DATA_W-1:0] m_tdata,   // row, note, velocity, channel,
                                                    // play_column, play_sequence, running
  output logic [1:0]                     m_tuser,   // event_kind
  output logic                           m_tlast,   // last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gss_pkg::*;

  gss_cmd_t  cmd;
  gss_stat_t st;

  assign cfg_ready = 1'b1;

  gss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .st      (st),
    .cmd     (cmd),
    .in_ready(s_tready)
  );

  gss_dp #(
    .SEQUENCES(SEQUENCES),
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

// ----- rtl/core/gss_checker.sv -----
// gss_checker: port-level assertions for grid_step_sequencer_top, attached
// by bind. Depends on gss_pkg.
module gss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gss_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser,
  input logic                           m_tlast
);
  import gss_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a command is in flight");

  // status beat and only it closes a command
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == EV_STATUS)))
    else $error("tlast does not match status beat");

  // reset empties output and starts the clearing pass
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block not quiet after reset");

endmodule

bind grid_step_sequencer_top gss_checker u_gss_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// ----- sim/grid_step_sequencer_top_tb.sv -----
// grid_step_sequencer_top_tb: self-checking bench for the grid step sequencer.
// Predicts note-on, note-off, trigger and status beats from its own pattern model;
// depends on gss_pkg and grid_step_sequencer_top.
`timescale 1ns / 100ps

module grid_step_sequencer_top_tb;
  import gss_pkg::*;

  localparam int NSEQ = 8;
  localparam int NROW = 12;
  localparam int NCOL = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] sq;
    logic [3:0] rw;
    logic [4:0] cl;
    logic [6:0] val;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] row;
    logic [6:0] note;
    logic [6:0] vel;
    logic [3:0] chan;
    logic [4:0] col;
    logic [3:0] seq;
    logic       run;
    logic       last;
  } event_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_step_sequencer_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer model state
  logic [6:0] pattern [NSEQ][NROW][NCOL];
  bit         note_off_due [NSEQ][NROW][NCOL];
  logic [6:0] row_note [NROW];
  int         play_col, play_seq;
  bit         playing;
  logic       mode_samples, loop_on, auto_on, linear_on;
  logic [3:0] active_reg, chan_reg;
  logic [5:0] steps_reg;
  logic [4:0] length_reg;

  cmd_beat_t   cmd_q [$];
  event_beat_t event_q [$];
  event_beat_t step_events [$];
  int errors = 0;
  bit s_fire = 0, m_fire = 0;
  bit steady = 0;
  int long_holds_asked = 0;

  function automatic void add_event(logic [1:0] kind, int r, logic [6:0] vel,
                                    logic [3:0] chan);
    event_beat_t e;
    e = '0;
    e.kind = kind;
    e.row = r[3:0];
    e.note = (kind == EV_STATUS) ? 7'd0 : row_note[r];
    e.vel = vel;
    e.chan = chan;
    step_events.push_back(e);
  endfunction

  function automatic void release_notes();
    bit any;
    for (int r = 0; r < NROW; r++) begin
      any = 0;
      for (int s = 0; s < NSEQ; s++)
        for (int c = 0; c < NCOL; c++)
          if (note_off_due[s][r][c]) begin
            any = 1;
            note_off_due[s][r][c] = 0;
          end
      if (any) add_event(EV_NOTE_OFF, r, 7'd0, chan_reg);
    end
  endfunction

  function automatic void play_step();
    int steps, act, len, off;
    bit any;
    logic [6:0] v;
    steps = (steps_reg < 1) ? 1 : (steps_reg > NCOL) ? NCOL : steps_reg;
    act = (active_reg < 1) ? 1 : (active_reg > NSEQ) ? NSEQ : active_reg;
    len = (length_reg >= steps) ? steps - 1 : length_reg;
    // stopped or position out of range: flush only
    if (!playing || play_col >= steps || play_seq >= act) begin
      playing = 0;
      release_notes();
      return;
    end
    for (int r = 0; r < NROW; r++) begin
      v = pattern[play_seq][r][play_col];
      if (!mode_samples) begin
        any = 0;
        for (int s = 0; s < act; s++)
          if (note_off_due[s][r][play_col]) begin
            any = 1;
            note_off_due[s][r][play_col] = 0;
          end
        if (any) add_event(EV_NOTE_OFF, r, 7'd0, chan_reg);
        if (v != 0) begin
          add_event(EV_NOTE_ON, r, v, chan_reg);
          off = play_col + len;
          if (off >= steps) off -= steps;
          note_off_due[play_seq][r][off] = 1;
        end
      end else if (v != 0) begin
        add_event(EV_TRIGGER, r, v, 4'd0);
      end
    end
    // column advance with loop, auto-cycle and linear rules
    play_col++;
    if (play_col == steps && loop_on) play_col = 0;
    if (auto_on && play_col == steps) begin
      play_seq++;
      play_col = 0;
      if (play_seq == act && !linear_on) play_seq = 0;
    end
    if (play_col >= steps) begin
      play_col = 0;
      playing = 0;
    end
    if (play_seq >= act) playing = 0;
  endfunction

  function automatic void sequence_beat(cmd_beat_t b);
    event_beat_t e;
    step_events.delete();
    case (b.cmd)
      CMD_TICK: play_step();
      CMD_WRITE_CELL: if (b.rw < NROW) pattern[b.sq][b.rw][b.cl] = b.val;
      CMD_WRITE_NOTE: if (b.rw < NROW) row_note[b.rw] = b.val;
      CMD_START: begin
        release_notes();
        play_col = 0;
        play_seq = 0;
        playing = 1;
      end
      CMD_STOP: begin
        release_notes();
        playing = 0;
      end
      default: ;
    endcase
    add_event(EV_STATUS, 0, 7'd0, 4'd0);
    foreach (step_events[k]) begin
      e = step_events[k];
      e.col = play_col[4:0];
      e.seq = play_seq[3:0];
      e.run = playing;
      e.last = (k == step_events.size() - 1);
      event_q.push_back(e);
    end
  endfunction

  // input side: model update on each accepted command beat
  always @(posedge clk) begin
    s_fire = s_tvalid && s_tready;
    if (s_fire)
      sequence_beat('{s_tuser, s_tdata[2:0], s_tdata[6:3], s_tdata[11:7], s_tdata[18:12]});
  end

  // command driver with random gaps
  int s_gap = 0;
  always @(negedge clk) begin
    cmd_beat_t b;
    logic nv;
    if (!rst && !(s_tvalid && !s_fire)) begin
      nv = 1'b0;
      if (s_gap > 0) begin
        s_gap--;
      end else if (cmd_q.size() > 0) begin
        b = cmd_q.pop_front();
        nv = 1'b1;
        s_tdata <= {5'd0, b.val, b.cl, b.rw, b.sq};
        s_tuser <= b.cmd;
        s_gap = steady ? 0 : $urandom_range(0, 4);
      end
      s_tvalid <= nv;
    end
  end

  // event receiver with random stalls and an occasional long hold-off
  int m_hold = 0, long_holds_done = 0;
  always @(negedge clk) begin
    if (long_holds_done < long_holds_asked) begin
      long_holds_done++;
      m_hold = 300;
    end
    if (m_fire) m_hold = steady ? 0 : $urandom_range(0, 4);
    if (m_hold > 0) begin
      m_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst;
    end
  end

  // event checker
  always @(posedge clk) begin
    event_beat_t got, want;
    m_fire = m_tvalid && m_tready;
    if (m_fire) begin
      got = '{m_tuser, m_tdata[3:0], m_tdata[10:4], m_tdata[17:11], m_tdata[21:18],
              m_tdata[26:22], m_tdata[30:27], m_tdata[31], m_tlast};
      if (event_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected event beat %h", $time, got);
      end else begin
        want = event_q.pop_front();
        if (got.kind != want.kind)
          $display("%0t: event_kind expected %0d got %0d", $time, want.kind, got.kind);
        if (got.row != want.row)
          $display("%0t: row expected %0d got %0d", $time, want.row, got.row);
        if (got.note != want.note)
          $display("%0t: note expected %0d got %0d", $time, want.note, got.note);
        if (got.vel != want.vel)
          $display("%0t: velocity expected %0d got %0d", $time, want.vel, got.vel);
        if (got.chan != want.chan)
          $display("%0t: channel expected %0d got %0d", $time, want.chan, got.chan);
        if (got.col != want.col)
          $display("%0t: play_column expected %0d got %0d", $time, want.col, got.col);
        if (got.seq != want.seq)
          $display("%0t: play_sequence expected %0d got %0d", $time, want.seq, got.seq);
        if (got.run != want.run)
          $display("%0t: running expected %0d got %0d", $time, want.run, got.run);
        if (got.last != want.last)
          $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
        if (got != want) errors++;
      end
    end
  end

  // watchdog on cycles with no beat moving anywhere
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL grid_step_sequencer_top");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (cmd_q.size() == 0 && !s_tvalid && event_q.size() == 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [5:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OUTPUT_MODE:  mode_samples = data[0];
      REG_ACTIVE_SEQ:   active_reg = data[3:0];
      REG_STEPS:        steps_reg = data;
      REG_NOTE_LENGTH:  length_reg = data[4:0];
      REG_LOOP:         loop_on = data[0];
      REG_AUTO_CYCLE:   auto_on = data[0];
      REG_LINEAR_CYCLE: linear_on = data[0];
      default:          chan_reg = data[3:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_cmd(logic [2:0] cmd, int sq, int rw, int cl, int val);
    cmd_q.push_back('{cmd, sq[2:0], rw[3:0], cl[4:0], val[6:0]});
  endtask

  // random phase: ticks mixed with cells mostly inside the played window, row notes, start, stop
  task automatic random_phase(int count, bit do_start);
    int steps, act, pick;
    steps = (steps_reg < 1) ? 1 : (steps_reg > NCOL) ? NCOL : steps_reg;
    act = (active_reg < 1) ? 1 : (active_reg > NSEQ) ? NSEQ : active_reg;
    if (do_start) push_cmd(CMD_START, 0, 0, 0, 0);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        push_cmd(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 75)
        push_cmd(CMD_WRITE_CELL, $urandom_range(0, act - 1), $urandom_range(0, NROW - 1),
                 $urandom_range(0, steps - 1), ($urandom_range(0, 3) == 0) ? 0 : $urandom);
      else if (pick < 83)
        push_cmd(CMD_WRITE_NOTE, $urandom, $urandom_range(0, 15), $urandom, $urandom);
      else if (pick < 88)
        push_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 92)
        push_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 96)
        push_cmd(CMD_WRITE_CELL, $urandom, $urandom, $urandom, $urandom);
      else
        push_cmd(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    foreach (pattern[s, r, c]) begin
      pattern[s][r][c] = '0;
      note_off_due[s][r][c] = 0;
    end
    foreach (row_note[r]) row_note[r] = '0;
    play_col = 0;
    play_seq = 0;
    playing = 0;
    mode_samples = 0; active_reg = 1; steps_reg = 16; length_reg = 1;
    loop_on = 1; auto_on = 0; linear_on = 0; chan_reg = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: edge fields, every command, out-of-range writes
    write_reg(REG_MIDI_CHANNEL, 6'd15);
    push_cmd(CMD_WRITE_NOTE, 0, 0, 0, 127);
    push_cmd(CMD_WRITE_NOTE, 7, 11, 31, 60);
    push_cmd(CMD_WRITE_NOTE, 0, 15, 0, 33);
    push_cmd(CMD_WRITE_CELL, 0, 0, 0, 127);
    push_cmd(CMD_WRITE_CELL, 0, 11, 0, 1);
    push_cmd(CMD_WRITE_CELL, 0, 0, 15, 64);
    push_cmd(CMD_WRITE_CELL, 7, 11, 31, 127);
    push_cmd(CMD_WRITE_CELL, 3, 14, 5, 99);
    push_cmd(3'd5, 7, 15, 31, 127);
    push_cmd(3'd6, 0, 0, 0, 0);
    push_cmd(3'd7, 5, 3, 9, 1);
    push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_START, 0, 0, 0, 0);
    repeat (4) push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_STOP, 0, 0, 0, 0);
    push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_START, 0, 0, 0, 0);
    repeat (17) push_cmd(CMD_TICK, 0, 0, 0, 0);
    wait_idle();

    // default registers but channel 15, with one long receiver hold-off
    long_holds_asked = 1;
    random_phase(50, 1);
    wait_idle();
    // samples mode, channel low
    write_reg(REG_OUTPUT_MODE, 6'd1);
    write_reg(REG_MIDI_CHANNEL, 6'd0);
    random_phase(40, 1);
    wait_idle();
    // shortest sequence, zero length
    write_reg(REG_OUTPUT_MODE, 6'd0);
    write_reg(REG_STEPS, 6'd1);
    write_reg(REG_NOTE_LENGTH, 6'd0);
    random_phase(40, 1);
    wait_idle();
    // full size, auto-cycle through all sequences, longest note
    write_reg(REG_STEPS, 6'd32);
    write_reg(REG_NOTE_LENGTH, 6'd31);
    write_reg(REG_ACTIVE_SEQ, 6'd8);
    write_reg(REG_AUTO_CYCLE, 6'd1);
    steady = 1;
    random_phase(70, 1);
    wait_idle();
    steady = 0;
    // linear cycle to the end, small pattern
    write_reg(REG_STEPS, 6'd3);
    write_reg(REG_ACTIVE_SEQ, 6'd3);
    write_reg(REG_LINEAR_CYCLE, 6'd1);
    write_reg(REG_NOTE_LENGTH, 6'd2);
    random_phase(50, 1);
    wait_idle();
    // no loop: natural end
    write_reg(REG_LOOP, 6'd0);
    write_reg(REG_AUTO_CYCLE, 6'd0);
    write_reg(REG_STEPS, 6'd5);
    random_phase(40, 1);
    wait_idle();
    // shrink window under a running position, then out-of-range registers
    write_reg(REG_LOOP, 6'd1);
    write_reg(REG_STEPS, 6'd20);
    write_reg(REG_ACTIVE_SEQ, 6'd4);
    write_reg(REG_LINEAR_CYCLE, 6'd0);
    write_reg(REG_AUTO_CYCLE, 6'd1);
    random_phase(40, 1);
    wait_idle();
    write_reg(REG_STEPS, 6'd2);
    write_reg(REG_ACTIVE_SEQ, 6'd1);
    random_phase(30, 0);
    wait_idle();
    write_reg(REG_STEPS, 6'd63);
    write_reg(REG_ACTIVE_SEQ, 6'd15);
    write_reg(REG_MIDI_CHANNEL, 6'd9);
    random_phase(40, 1);
    wait_idle();
    write_reg(REG_STEPS, 6'd0);
    write_reg(REG_ACTIVE_SEQ, 6'd0);
    write_reg(REG_NOTE_LENGTH, 6'd17);
    random_phase(30, 1);
    wait_idle();
    write_reg(REG_STEPS, 6'd7);
    write_reg(REG_ACTIVE_SEQ, 6'd2);
    write_reg(REG_NOTE_LENGTH, 6'd4);
    write_reg(REG_AUTO_CYCLE, 6'd0);
    random_phase(60, 1);
    wait_idle();

    if (errors == 0)
      $display("PASS grid_step_sequencer_top");
    else
      $display("FAIL grid_step_sequencer_top");
    $finish;
  end

endmodule
